### hdl/tlca_pkg.sv
`timescale 1ns / 1ps

package tlca_pkg;

  localparam int unsigned NODES   = 1024;
  localparam int unsigned LEVELS  = 11;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned DEPTH_W = NODE_W + 1;
  localparam int unsigned LVL_W   = $clog2(LEVELS);

  typedef enum logic {
    OP_ATTACH = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef logic [NODE_W-1:0] node_t;

  // One row of the node table: everything known about one node.
  typedef struct packed {
    logic                           attached;
    logic [DEPTH_W-1:0]             depth;
    logic [LEVELS-1:0][NODE_W-1:0]  anc;
  } row_t;

  typedef struct packed {
    logic             load_in;
    logic             check;
    logic             sel_anc;
    logic             anc_step;
    logic             lift_step;
    logic             meet_step;
    logic             res_self;
    logic             res_parent;
    logic             out_load;
    logic             mem_we;
    logic             mem_clr;
    logic [LVL_W-1:0] lvl;
    node_t            clr_addr;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic attach_ok;
    logic diff_bit;
    logic same;
  } sts_t;

endpackage

### hdl/tlca_if.sv
`timescale 1ns / 1ps

interface tlca_in_if;
  import tlca_pkg::*;

  logic  valid;
  logic  ready;
  logic  opcode;
  node_t node_a;
  node_t node_b;

  modport source (output valid, output opcode, output node_a, output node_b, input ready);
  modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

interface tlca_out_if;
  import tlca_pkg::*;

  logic  valid;
  logic  ready;
  node_t ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink   (input valid, input ancestor, output ready);
endinterface

### hdl/tlca_mem.sv
`timescale 1ns / 1ps

module tlca_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  tlca_pkg::node_t waddr_i,
  input  tlca_pkg::row_t  wdata_i,
  input  tlca_pkg::node_t raddr_a_i,
  input  tlca_pkg::node_t raddr_b_i,
  output tlca_pkg::row_t  rdata_a_o,
  output tlca_pkg::row_t  rdata_b_o
);
  import tlca_pkg::*;

  row_t mem [NODES];
  row_t rdata_a_q;
  row_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hdl/tlca_dp.sv
`timescale 1ns / 1ps

module tlca_dp (
  input  logic            clk_i,
  input  tlca_pkg::cmd_t  cmd_i,
  output tlca_pkg::sts_t  sts_o,
  input  logic            opcode_i,
  input  tlca_pkg::node_t node_a_i,
  input  tlca_pkg::node_t node_b_i,
  output tlca_pkg::node_t ancestor_o,
  output logic            mem_we_o,
  output tlca_pkg::node_t waddr_o,
  output tlca_pkg::row_t  wdata_o,
  output tlca_pkg::node_t raddr_a_o,
  output tlca_pkg::node_t raddr_b_o,
  input  tlca_pkg::row_t  rdata_a_i,
  input  tlca_pkg::row_t  rdata_b_i
);
  import tlca_pkg::*;

  op_e                           op_q;
  node_t                         x_q;
  node_t                         y_q;
  node_t                         res_q;
  node_t                         ans_q;
  logic [DEPTH_W-1:0]            diff_q;
  logic [DEPTH_W-1:0]            dep_q;
  logic [LEVELS-1:0][NODE_W-1:0] anc_q;

  logic [LVL_W-1:0]   lvl_m1;
  node_t              ax;
  node_t              ay;
  node_t              ax_m1;
  logic [DEPTH_W-1:0] dep_a;
  logic [DEPTH_W-1:0] dep_b;
  row_t               new_row;

  assign lvl_m1 = cmd_i.lvl - LVL_W'(1);
  assign ax     = rdata_a_i.anc[cmd_i.lvl];
  assign ay     = rdata_b_i.anc[cmd_i.lvl];
  assign ax_m1  = rdata_a_i.anc[lvl_m1];
  assign dep_a  = rdata_a_i.depth;
  assign dep_b  = rdata_b_i.depth;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= op_e'(opcode_i);
      x_q  <= node_a_i;
      y_q  <= node_b_i;
    end
    if (cmd_i.check) begin
      if (op_q == OP_QUERY) begin
        // The deeper node goes to x. When the shallower node sits at depth
        // zero, lifting always reaches the sentinel, so x starts there.
        if (dep_a < dep_b) begin
          y_q    <= x_q;
          diff_q <= (dep_a == '0) ? '0 : dep_b - dep_a;
          x_q    <= (dep_a == '0) ? '0 : y_q;
        end else begin
          diff_q <= (dep_b == '0) ? '0 : dep_a - dep_b;
          if (dep_b == '0) begin
            x_q <= '0;
          end
        end
      end else begin
        dep_q    <= dep_b + DEPTH_W'(1);
        anc_q[0] <= y_q;
      end
    end
    if (cmd_i.anc_step) begin
      anc_q[cmd_i.lvl] <= ax_m1;
    end
    if (cmd_i.lift_step) begin
      x_q <= ax;
    end
    if (cmd_i.meet_step && (ax != ay)) begin
      x_q <= ax;
      y_q <= ay;
    end
    if (cmd_i.res_self) begin
      res_q <= x_q;
    end
    if (cmd_i.res_parent) begin
      res_q <= rdata_a_i.anc[0];
    end
    if (cmd_i.out_load) begin
      ans_q <= res_q;
    end
  end

  always_comb begin
    new_row.attached = 1'b1;
    new_row.depth    = dep_q;
    new_row.anc      = anc_q;
  end

  assign raddr_a_o  = cmd_i.sel_anc ? anc_q[lvl_m1] : x_q;
  assign raddr_b_o  = y_q;
  assign mem_we_o   = cmd_i.mem_we;
  assign waddr_o    = cmd_i.mem_clr ? cmd_i.clr_addr : x_q;
  assign wdata_o    = cmd_i.mem_clr ? row_t'('0) : new_row;
  assign ancestor_o = ans_q;

  always_comb begin
    sts_o.is_query  = (op_q == OP_QUERY);
    sts_o.attach_ok = (x_q != '0) && !rdata_a_i.attached &&
                      ((y_q == '0) || rdata_b_i.attached);
    sts_o.diff_bit  = diff_q[cmd_i.lvl];
    sts_o.same      = (x_q == y_q);
  end

endmodule

### hdl/tlca_ctrl.sv
`timescale 1ns / 1ps

module tlca_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  tlca_pkg::sts_t sts_i,
  output tlca_pkg::cmd_t cmd_o
);
  import tlca_pkg::*;

  typedef enum logic [14:0] {
    ST_CLEAR   = 15'h0001,
    ST_IDLE    = 15'h0002,
    ST_READ    = 15'h0004,
    ST_CHECK   = 15'h0008,
    ST_ANC_RD  = 15'h0010,
    ST_ANC_WT  = 15'h0020,
    ST_WRITE   = 15'h0040,
    ST_LIFT_RD = 15'h0080,
    ST_LIFT_WT = 15'h0100,
    ST_SAME    = 15'h0200,
    ST_MEET_RD = 15'h0400,
    ST_MEET_WT = 15'h0800,
    ST_PAR_RD  = 15'h1000,
    ST_PAR_WT  = 15'h2000,
    ST_OUT     = 15'h4000
  } state_e;

  localparam logic [LVL_W-1:0] LvlTop  = LVL_W'(LEVELS - 1);
  localparam node_t            ClrLast = NODE_W'(NODES - 1);

  state_e           state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  node_t            clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  cmd_t             cmd;
  logic             in_ready;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    in_ready    = 1'b0;
    cmd          = '0;
    cmd.lvl      = lvl_q;
    cmd.clr_addr = clr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cmd.mem_we  = 1'b1;
        cmd.mem_clr = 1'b1;
        clr_d       = clr_q + NODE_W'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts_i.is_query) begin
          lvl_d   = LvlTop;
          state_d = ST_LIFT_RD;
        end else if (sts_i.attach_ok) begin
          lvl_d   = LVL_W'(1);
          state_d = ST_ANC_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ANC_RD: begin
        cmd.sel_anc = 1'b1;
        state_d     = ST_ANC_WT;
      end
      ST_ANC_WT: begin
        cmd.anc_step = 1'b1;
        if (lvl_q == LvlTop) begin
          state_d = ST_WRITE;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_ANC_RD;
        end
      end
      ST_WRITE: begin
        cmd.mem_we = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_LIFT_RD: begin
        // Levels whose bit of the depth difference is clear skip ST_LIFT_WT.
        if (sts_i.diff_bit) begin
          state_d = ST_LIFT_WT;
        end else if (lvl_q == '0) begin
          state_d = ST_SAME;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      ST_LIFT_WT: begin
        cmd.lift_step = 1'b1;
        if (lvl_q == '0) begin
          state_d = ST_SAME;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = ST_LIFT_RD;
        end
      end
      ST_SAME: begin
        if (sts_i.same) begin
          cmd.res_self = 1'b1;
          state_d      = ST_OUT;
        end else begin
          lvl_d   = LvlTop;
          state_d = ST_MEET_RD;
        end
      end
      ST_MEET_RD: begin
        state_d = ST_MEET_WT;
      end
      ST_MEET_WT: begin
        cmd.meet_step = 1'b1;
        if (lvl_q == '0) begin
          state_d = ST_PAR_RD;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = ST_MEET_RD;
        end
      end
      ST_PAR_RD: begin
        state_d = ST_PAR_WT;
      end
      ST_PAR_WT: begin
        cmd.res_parent = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      lvl_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

### hdl/tree_lca_binary_lifting_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Payload                 | Items
// req_i   | in        | opcode, node_a, node_b  | attach or query
// rsp_o   | out       | ancestor                | one per query
//
// An attach reads the node table once per ancestor level, then writes its row;
// an ignored one returns to idle after its check. Each table read is registered,
// so each step that uses one costs a read state and a use state. After reset a
// pass clears all 1024 rows of the node table before the first item. A finished
// result waits in the output register while the next item is taken; a later
// query holds in its last step until that register is free.

module tree_lca_binary_lifting_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlca_in_if.sink    req_i,
  tlca_out_if.source rsp_o
);
  import tlca_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  logic  mem_we;
  node_t waddr;
  row_t  wdata;
  node_t raddr_a;
  node_t raddr_b;
  row_t  rdata_a;
  row_t  rdata_b;

  tlca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlca_dp u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .opcode_i  (req_i.opcode),
    .node_a_i  (req_i.node_a),
    .node_b_i  (req_i.node_b),
    .ancestor_o(rsp_o.ancestor),
    .mem_we_o  (mem_we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b)
  );

  tlca_mem u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

endmodule

### hdl/tlca_chk.sv
`timescale 1ns / 1ps

module tlca_chk (
  input logic        clk_i,
  input logic        rst_ni,
  tlca_in_if.sink    req_i,
  tlca_out_if.source rsp_o
);

  // The node table is being cleared right after reset, so no item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_i.ready)
    else $error("item taken during the clearing pass");

  // One item at a time: taking an item closes the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("input stayed open after an item was taken");

  // A new result is only posted from the busy state, never while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result appeared while the block was idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rsp_o.ancestor)))
    else $error("stalled result changed or dropped");

endmodule

bind tree_lca_binary_lifting_top tlca_chk u_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_i (req_i),
  .rsp_o (rsp_o)
);

### test/tree_lca_binary_lifting_top_tb.sv
`timescale 1ns / 1ps

module tree_lca_binary_lifting_top_tb;
  import tlca_pkg::*;

  localparam int unsigned PHASE_ITEMS   = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 100;

  // Tracks the tree as the block should see it and queues the ancestor that
  // each accepted query must return.
  class lca_scoreboard;
    logic [DEPTH_W-1:0] depth [NODES];
    node_t              jump [LEVELS][NODES];
    bit                 attached [NODES];
    node_t              members [$];
    node_t              expected_ancestors [$];
    int unsigned        mismatches;
    int unsigned        answered;
    int unsigned        max_depth;

    function new();
      foreach (depth[n]) depth[n] = '0;
      foreach (jump[l, n]) jump[l][n] = '0;
      mismatches = 0;
      answered   = 0;
      max_depth  = 0;
    endfunction

    function bit graft(node_t node, node_t parent);
      if (node == '0 || attached[node]) return 1'b0;
      if (parent != '0 && !attached[parent]) return 1'b0;
      attached[node] = 1'b1;
      depth[node]    = depth[parent] + 1'b1;
      jump[0][node]  = parent;
      for (int l = 1; l < LEVELS; l++) jump[l][node] = jump[l-1][jump[l-1][node]];
      if (depth[node] > max_depth) max_depth = depth[node];
      members.push_back(node);
      return 1'b1;
    endfunction

    function node_t meet(node_t x, node_t y);
      node_t t;
      if (depth[x] < depth[y]) begin
        t = x;
        x = y;
        y = t;
      end
      for (int l = LEVELS - 1; l >= 0; l--) begin
        if (depth[jump[l][x]] >= depth[y]) x = jump[l][x];
      end
      if (x == y) return x;
      for (int l = LEVELS - 1; l >= 0; l--) begin
        if (jump[l][x] != jump[l][y]) begin
          x = jump[l][x];
          y = jump[l][y];
        end
      end
      return jump[0][x];
    endfunction

    // Returns 1 when the item changes the tree or produces an ancestor.
    function bit accept(op_e op, node_t a, node_t b);
      if (op == OP_QUERY) begin
        expected_ancestors.push_back(meet(a, b));
        return 1'b1;
      end
      return graft(a, b);
    endfunction

    function void check(node_t got);
      node_t want;
      answered++;
      if (expected_ancestors.size() == 0) begin
        mismatches++;
        $display("%0t: ancestor %0d arrived with no query outstanding", $time, got);
        return;
      end
      want = expected_ancestors.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: ancestor mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   attach_pct     = 40;
  int unsigned   chain_pct      = 50;
  int unsigned   effective      = 0;
  int unsigned   sent           = 0;
  int unsigned   cycles         = 0;
  lca_scoreboard tracker;

  tlca_in_if  req_if ();
  tlca_out_if rsp_if ();

  tree_lca_binary_lifting_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("[tree_lca_binary_lifting_top] ERROR");
      $finish;
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready) tracker.check(rsp_if.ancestor);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(op_e op, node_t a, node_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.node_a <= a;
    req_if.node_b <= b;
    do @(posedge clk); while (!req_if.ready);
    sent++;
    if (tracker.accept(op, a, b)) effective++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (tracker.expected_ancestors.size() != 0);
  endtask

  function automatic node_t any_member();
    if (tracker.members.size() == 0) return node_t'($urandom_range(NODES - 1));
    return tracker.members[$urandom_range(tracker.members.size() - 1)];
  endfunction

  function automatic node_t recent_member();
    int unsigned n;
    n = tracker.members.size();
    if (n == 0) return '0;
    return tracker.members[n - 1 - $urandom_range(n < 8 ? n - 1 : 7)];
  endfunction

  function automatic node_t fresh_node();
    node_t v;
    if (tracker.members.size() >= NODES - 1) return node_t'($urandom_range(NODES - 1));
    do v = node_t'($urandom_range(NODES - 1, 1)); while (tracker.attached[v]);
    return v;
  endfunction

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned grow,
                           int unsigned chain);
    int unsigned start;
    int unsigned pick;
    op_e         op;
    node_t       a;
    node_t       b;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    attach_pct     = grow;
    chain_pct      = chain;
    start          = effective;
    while (effective - start < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Malformed or odd items mixed into the stream.
        case ($urandom_range(5))
          0: begin
            op = OP_ATTACH;
            a  = any_member();
            b  = any_member();
          end
          1: begin
            op = OP_ATTACH;
            a  = fresh_node();
            b  = ($urandom_range(3) == 0) ? a : fresh_node();
          end
          2: begin
            op = OP_ATTACH;
            a  = '0;
            b  = any_member();
          end
          3: begin
            op = OP_QUERY;
            a  = fresh_node();
            b  = any_member();
          end
          4: begin
            op = OP_QUERY;
            a  = '0;
            b  = any_member();
          end
          default: begin
            op = op_e'($urandom_range(1));
            a  = node_t'($urandom);
            b  = node_t'($urandom);
          end
        endcase
      end else if (pick < 10 + attach_pct && tracker.members.size() < NODES - 1) begin
        op = OP_ATTACH;
        a  = fresh_node();
        if (tracker.members.size() == 0 || $urandom_range(99) < 10) b = '0;
        else if ($urandom_range(99) < chain_pct) b = tracker.members[$];
        else b = any_member();
      end else begin
        op   = OP_QUERY;
        pick = $urandom_range(99);
        if (pick < 15) begin
          a = any_member();
          b = a;
        end else if (pick < 50) begin
          a = recent_member();
          b = recent_member();
        end else begin
          a = any_member();
          b = any_member();
        end
      end
      send(op, a, b);
    end
  endtask

  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.opcode = OP_ATTACH;
    req_if.node_a = '0;
    req_if.node_b = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty tree, ignored attaches, a small tree and queries over it.
    send(OP_QUERY, 10'd0, 10'd0);
    send(OP_ATTACH, 10'd0, 10'd0);
    send(OP_ATTACH, 10'd5, 10'd7);
    send(OP_ATTACH, 10'd9, 10'd9);
    send(OP_ATTACH, 10'd1023, 10'd0);
    send(OP_ATTACH, 10'd1, 10'd1023);
    send(OP_ATTACH, 10'd2, 10'd1);
    send(OP_ATTACH, 10'd3, 10'd1);
    send(OP_ATTACH, 10'd1, 10'd0);
    send(OP_QUERY, 10'd2, 10'd3);
    send(OP_QUERY, 10'd3, 10'd2);
    send(OP_QUERY, 10'd2, 10'd2);
    send(OP_QUERY, 10'd2, 10'd1023);
    send(OP_QUERY, 10'd1023, 10'd2);
    send(OP_QUERY, 10'd512, 10'd512);
    send(OP_QUERY, 10'd2, 10'd512);
    send(OP_ATTACH, 10'd512, 10'd0);
    send(OP_QUERY, 10'd2, 10'd512);
    send(OP_QUERY, 10'd1023, 10'd0);
    send(OP_QUERY, 10'd0, 10'd1023);
    send(OP_ATTACH, 10'd1022, 10'd1023);
    send(OP_QUERY, 10'd1022, 10'd3);
    drain();

    // The first phase builds a long chain so that the upper lifting levels are used.
    run_phase(0, 0, 70, 97);
    drain();
    run_phase(54, 0, 40, 60);
    drain();
    run_phase(0, 54, 40, 60);
    drain();
    run_phase(25, 25, 40, 60);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d items: %0d ancestors returned over a tree of %0d nodes, deepest %0d.",
             sent, tracker.answered, tracker.members.size(), tracker.max_depth);
    $display("Traffic ran with no stalls, sender gaps, receiver stalls and both; %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("[tree_lca_binary_lifting_top] OK");
    end else begin
      $display("[tree_lca_binary_lifting_top] ERROR");
    end
    $finish;
  end

endmodule
